// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/efr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame receiver package
// Types and codes shared by the frame receiver modules.
// ---------------------------------------------------------------------------
package efr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CKLO = 3'd3,
        PH_CKHI = 3'd4
    } t_phase;

    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_ESCAPE = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] escape_byte;
        logic [7:0] copy_limit;
    } t_cfg;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_value;
        logic [7:0] byte_index;
        logic       frame_good;
        logic [7:0] frame_length;
    } t_result;

endpackage

// ----- hdl/efr_deframer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame deframer
// Phase machine, destuffing, checksum accumulation and result decode.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module efr_deframer
    import efr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_low, n_low;

    logic       w_in_frame;
    logic       w_summed;
    logic       w_esc_start;
    logic [7:0] w_val;
    logic [7:0] w_cnt_inc;

    assign w_in_frame  = (r_phase == PH_LEN) || (r_phase == PH_DATA) ||
                         (r_phase == PH_CKLO) || (r_phase == PH_CKHI);
    assign w_summed    = (r_phase == PH_LEN) || (r_phase == PH_DATA);
    assign w_esc_start = !r_esc && (i_byte == i_cfg.escape_byte);
    assign w_val       = r_esc ? (i_byte ^ i_cfg.escape_byte) : i_byte;
    assign w_cnt_inc   = r_cnt + 8'd1;

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_sum   = r_sum;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_low   = r_low;
        if (!w_in_frame) begin
            n_phase = PH_IDLE;
            if (i_byte == i_cfg.header_byte) begin
                n_phase = PH_LEN;
                n_esc   = 1'b0;
                n_sum   = 16'd0;
                n_len   = 8'd0;
                n_cnt   = 8'd0;
                n_low   = 8'd0;
            end
        end else begin
            if (w_summed) begin
                n_sum = r_sum + {8'd0, i_byte};
            end
            if (w_esc_start) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                unique case (r_phase)
                    PH_LEN: begin
                        n_len   = w_val;
                        n_cnt   = 8'd0;
                        n_phase = (w_val == 8'd0) ? PH_CKLO : PH_DATA;
                    end
                    PH_DATA: begin
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc == r_len) begin
                            n_phase = PH_CKLO;
                        end
                    end
                    PH_CKLO: begin
                        n_low   = w_val;
                        n_phase = PH_CKHI;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result decode.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (w_in_frame && !w_esc_start) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (r_cnt < i_cfg.copy_limit) begin
                        o_res_valid       = 1'b1;
                        o_res.result_kind = KIND_DATA;
                        o_res.data_value  = w_val;
                        o_res.byte_index  = r_cnt;
                    end
                end
                PH_CKHI: begin
                    o_res_valid        = 1'b1;
                    o_res.result_kind  = KIND_STATUS;
                    o_res.frame_good   = ({w_val, r_low} == r_sum);
                    o_res.frame_length = r_len;
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_esc   <= 1'b0;
            r_sum   <= 16'd0;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            r_low   <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_low   <= n_low;
        end
    end

    `ASSERT_NEXT(a_status_ends_frame, i_clk, i_rst_n,
        i_fire && o_res_valid && (o_res.result_kind == KIND_STATUS), r_phase == PH_IDLE)
    `ASSERT_SAME(a_idle_no_escape, i_clk, i_rst_n, r_phase == PH_IDLE, !r_esc)
    `ASSERT_SAME(a_count_below_length, i_clk, i_rst_n, r_phase == PH_DATA, r_cnt < r_len)

endmodule

// ----- hdl/efr_out_reg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result register
// Holds one result transaction until the consumer takes it.
// ---------------------------------------------------------------------------
module efr_out_reg
    import efr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hdl/escaped_frame_receiver.sv -----
// An accepted byte is held in the input register until the output register is free;
// its result then goes into the output register, which holds it until the consumer takes it.
// Throughput: one wire byte per cycle while the result side does not stall.
// Stall from the output side reaches the input stall in the same cycle; nothing is dropped.
// Reset is synchronous and active low: control state clears, config registers return to defaults.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame deframer with a 16-bit additive checksum.
// ---------------------------------------------------------------------------
module escaped_frame_receiver
    import efr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input byte channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_wire_byte,
    // Result channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_result_kind,
    output logic [7:0] o_data_value,
    output logic [7:0] o_byte_index,
    output logic       o_frame_good,
    output logic [7:0] o_frame_length,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Configuration registers. The user must write them only while the block is idle, as the
    // block does not enforce it; writes are always ready and take effect from the next byte.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte <= 8'd126;
            r_cfg.escape_byte <= 8'd125;
            r_cfg.copy_limit  <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_cfg.header_byte <= i_cfg_data;
                CFG_ESCAPE: r_cfg.escape_byte <= i_cfg_data;
                CFG_LIMIT:  r_cfg.copy_limit  <= i_cfg_data;
                default:    r_cfg             <= r_cfg;
            endcase
        end
    end

    // Input register. A held byte is consumed by the deframer whenever the
    // result register can take whatever that byte produces, which is the
    // case when it is empty or being emptied this cycle.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_out_free;
    logic       w_fire;

    assign w_out_free = !o_valid || !i_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_wire_byte;
        end
    end

    // Deframer: one byte per consumed transaction, zero or one result.
    logic    w_res_valid;
    t_result w_res;

    efr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register feeding the output channel.
    t_result w_out_res;

    efr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (w_out_res)
    );

    assign o_result_kind  = w_out_res.result_kind;
    assign o_data_value   = w_out_res.data_value;
    assign o_byte_index   = w_out_res.byte_index;
    assign o_frame_good   = w_out_res.frame_good;
    assign o_frame_length = w_out_res.frame_length;

endmodule

// ----- bench/escaped_frame_receiver_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Escaped frame receiver testbench
// Feeds byte-stuffed frames and line noise into the receiver, predicts every
// data and status result, and compares the results field by field.
// ---------------------------------------------------------------------------
module escaped_frame_receiver_tb;
    import efr_pkg::*;

    // Register values after reset.
    localparam logic [7:0] HEADER_RESET = 8'd126;
    localparam logic [7:0] ESCAPE_RESET = 8'd125;
    localparam logic [7:0] LIMIT_RESET  = 8'd255;

    // Index 3 has no register behind it, so a write there must change nothing.
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    // A result passes only the input and output registers, so the settle time
    // after the last result is enough for the pipe to be empty.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_wire_byte = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_data_value;
    logic [7:0] o_byte_index;
    logic       o_frame_good;
    logic [7:0] o_frame_length;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = 2'd0;
    logic [7:0] i_cfg_data = 8'd0;

    escaped_frame_receiver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_wire_byte    (i_wire_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_data_value   (o_data_value),
        .o_byte_index   (o_byte_index),
        .o_frame_good   (o_frame_good),
        .o_frame_length (o_frame_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Stimulus side state. The generator keeps its own copy of the registers
    // so that it can stuff bytes and build checksums for the current setting.
    // -----------------------------------------------------------------------
    logic [7:0]  wire_bytes_q[$];   // raw line bytes waiting for the driver
    logic [7:0]  frame_payload[$];  // chosen data for the next frame, if any
    logic [7:0]  gen_hdr = HEADER_RESET;
    logic [7:0]  gen_esc = ESCAPE_RESET;
    logic [15:0] frame_sum;
    int          wire_items = 0;    // frame bytes queued, line noise excluded
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic        in_fire = 1'b0;    // the byte on the input went in last edge

    // -----------------------------------------------------------------------
    // Predictor state: the receiver's registers and frame tracking as this
    // bench sees them, updated on every accepted transaction.
    // -----------------------------------------------------------------------
    t_cfg        model_cfg;
    t_phase      rx_phase;
    logic        rx_esc_pending;
    logic [15:0] rx_sum;
    logic [7:0]  rx_len;
    logic [7:0]  rx_count;
    logic [7:0]  rx_ck_lo;
    t_result     rx_results_q[$];   // results the receiver still owes us
    int          mismatch_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A generous bound well above the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Walks one raw byte through the frame state machine and queues the
    // result it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        t_result    r;
        r = '0;
        if (!(rx_phase inside {PH_LEN, PH_DATA, PH_CKLO, PH_CKHI})) begin
            // Idle: everything but the header byte is line noise.
            rx_phase = PH_IDLE;
            if (b == model_cfg.header_byte) begin
                rx_phase = PH_LEN;
                rx_esc_pending = 1'b0;
                rx_sum = '0;
                rx_len = '0;
                rx_count = '0;
                rx_ck_lo = '0;
            end
            return;
        end
        // The sum covers raw wire bytes of the length and data fields,
        // escape bytes included, but never the checksum bytes.
        if (rx_phase == PH_LEN || rx_phase == PH_DATA) begin
            rx_sum = rx_sum + 16'(b);
        end
        if (!rx_esc_pending && b == model_cfg.escape_byte) begin
            rx_esc_pending = 1'b1;
            return;
        end
        v = rx_esc_pending ? (b ^ model_cfg.escape_byte) : b;
        rx_esc_pending = 1'b0;
        case (rx_phase)
            PH_LEN: begin
                rx_len = v;
                rx_count = '0;
                rx_phase = (v == 8'd0) ? PH_CKLO : PH_DATA;
            end
            PH_DATA: begin
                if (rx_count < model_cfg.copy_limit) begin
                    r.result_kind = KIND_DATA;
                    r.data_value = v;
                    r.byte_index = rx_count;
                    rx_results_q.push_back(r);
                end
                rx_count = rx_count + 8'd1;
                if (rx_count == rx_len) begin
                    rx_phase = PH_CKLO;
                end
            end
            PH_CKLO: begin
                rx_ck_lo = v;
                rx_phase = PH_CKHI;
            end
            default: begin
                r.result_kind = KIND_STATUS;
                r.frame_good = ({v, rx_ck_lo} == rx_sum);
                r.frame_length = rx_len;
                rx_results_q.push_back(r);
                rx_phase = PH_IDLE;
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where the receiver's
    // outputs still hold the values that the edge acts on.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n) begin
            model_cfg.header_byte = HEADER_RESET;
            model_cfg.escape_byte = ESCAPE_RESET;
            model_cfg.copy_limit = LIMIT_RESET;
            rx_phase = PH_IDLE;
            rx_esc_pending = 1'b0;
            rx_sum = '0;
            rx_len = '0;
            rx_count = '0;
            rx_ck_lo = '0;
            rx_results_q.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got.result_kind = o_result_kind;
                got.data_value = o_data_value;
                got.byte_index = o_byte_index;
                got.frame_good = o_frame_good;
                got.frame_length = o_frame_length;
                if (rx_results_q.size() == 0) begin
                    log_failure($sformatf("unexpected result kind=%0d value=%02h index=%0d",
                        got.result_kind, got.data_value, got.byte_index));
                end else begin
                    want = rx_results_q.pop_front();
                    if (got.result_kind != want.result_kind
                            || got.data_value != want.data_value
                            || got.byte_index != want.byte_index
                            || got.frame_good != want.frame_good
                            || got.frame_length != want.frame_length) begin
                        log_failure($sformatf({"result mismatch: expected kind=%0d ",
                            "value=%02h index=%0d good=%0d length=%0d, got kind=%0d ",
                            "value=%02h index=%0d good=%0d length=%0d"},
                            want.result_kind, want.data_value, want.byte_index,
                            want.frame_good, want.frame_length,
                            got.result_kind, got.data_value, got.byte_index,
                            got.frame_good, got.frame_length));
                    end
                end
            end
            // A register write lands at this edge and applies from the next byte.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEADER: model_cfg.header_byte = i_cfg_data;
                    CFG_ESCAPE: model_cfg.escape_byte = i_cfg_data;
                    CFG_LIMIT:  model_cfg.copy_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                deframe_byte(i_wire_byte);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Driver: a new byte is offered at the falling edge only once the old one
    // has gone in, so a stalled transaction never changes under the block.
    // Whether to idle is decided at random and never looks at the stall.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (wire_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_wire_byte <= wire_bytes_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side stall. A hold-off request keeps the stall up for a long
    // stretch so that the receiver backs up into its input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Register write through the configuration channel; the generator's
    // copy follows along so that later frames use the new values.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HEADER: gen_hdr = val;
            CFG_ESCAPE: gen_esc = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Queues one field value, stuffed when it collides with the escape byte
    // and now and then when it does not, which the receiver must also accept.
    task automatic put_field(input logic [7:0] v, input logic summed, input int esc_pct);
        if (v == gen_esc || $urandom_range(0, 99) < esc_pct) begin
            wire_bytes_q.push_back(gen_esc);
            wire_bytes_q.push_back(v ^ gen_esc);
            if (summed) begin
                frame_sum = frame_sum + 16'(gen_esc) + 16'(v ^ gen_esc);
            end
            wire_items += 2;
        end else begin
            wire_bytes_q.push_back(v);
            if (summed) begin
                frame_sum = frame_sum + 16'(v);
            end
            wire_items++;
        end
    endtask

    // Builds a frame of len data bytes. Only keep of them go out; when keep
    // falls short the frame is cut off without a checksum. Data comes from
    // frame_payload while it lasts and is random after that.
    task automatic send_frame(input int len, input logic corrupt, input int esc_pct,
                              input int keep);
        logic [15:0] ck;
        logic [7:0]  d;
        wire_bytes_q.push_back(gen_hdr);
        wire_items++;
        frame_sum = '0;
        put_field(8'(len), 1'b1, esc_pct);
        for (int i = 0; i < keep; i++) begin
            d = (frame_payload.size() != 0) ? frame_payload.pop_front() : 8'($urandom);
            put_field(d, 1'b1, esc_pct);
        end
        if (keep == len) begin
            ck = frame_sum;
            if (corrupt) begin
                ck = ck ^ 16'($urandom_range(1, 65535));
            end
            put_field(ck[7:0], 1'b0, esc_pct);
            put_field(ck[15:8], 1'b0, esc_pct);
        end
    endtask

    // Mostly well-formed frames with random content; the rest are frames with
    // a bad checksum, frames cut short, and bursts of line noise.
    task automatic run_traffic(input int target);
        int stop;
        int len;
        int pick;
        int esc_pct;
        stop = wire_items + target;
        while (wire_items < stop) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            esc_pct = $urandom_range(0, 30);
            if (pick < 72) begin
                send_frame(len, 1'b0, esc_pct, len);
            end else if (pick < 84) begin
                send_frame(len, 1'b1, esc_pct, len);
            end else if (pick < 92) begin
                send_frame(len, 1'b0, esc_pct, (len == 0) ? 0 : $urandom_range(0, len - 1));
            end else begin
                repeat ($urandom_range(1, 4)) wire_bytes_q.push_back(8'($urandom));
            end
        end
    endtask

    // Waits until every queued byte has gone in and every predicted result
    // has come out, then lets the pipe settle before anything is rewritten.
    task automatic drain_block();
        int waited = 0;
        while ((wire_bytes_q.size() != 0 || i_valid || rx_results_q.size() != 0)
                && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Test sequence. Each phase runs under one register setting and one idle
    // pattern, and registers are only rewritten once the receiver is drained.
    // -----------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset setting. A zero-length frame goes
        // first. The next one carries a header byte as plain data, the value
        // 0xFF and a stuffed escape byte, and its checksum is wrong. The last
        // one is fully stuffed: an escape followed by an escape, an escape
        // followed by a raw header byte, and stuffed checksum bytes.
        send_frame(0, 1'b0, 0, 0);
        frame_payload = '{HEADER_RESET, 8'hFF, ESCAPE_RESET};
        send_frame(3, 1'b1, 0, 3);
        frame_payload = '{8'h00, ESCAPE_RESET ^ HEADER_RESET};
        send_frame(2, 1'b0, 100, 2);
        drain_block();

        // Reset setting, no idling, with one frame of the largest length so
        // the byte index runs all the way up.
        send_frame(255, 1'b0, 5, 255);
        run_traffic(120);
        drain_block();

        // Extreme register values: nothing is copied, only status comes out.
        write_reg(CFG_HEADER, 8'h00);
        write_reg(CFG_ESCAPE, 8'hFF);
        write_reg(CFG_LIMIT, 8'h00);
        send_idle_pct = 60;
        run_traffic(100);
        drain_block();

        // Opposite extremes and a short copy limit, with result side stalls.
        write_reg(CFG_HEADER, 8'hFF);
        write_reg(CFG_ESCAPE, 8'h00);
        write_reg(CFG_LIMIT, 8'd3);
        send_idle_pct = 0;
        stall_pct = 60;
        run_traffic(100);
        drain_block();

        // Random setting, a write to an unmapped index, light idling on both
        // sides.
        write_reg(CFG_HEADER, 8'($urandom));
        write_reg(CFG_ESCAPE, 8'($urandom));
        write_reg(CFG_LIMIT, 8'($urandom_range(1, 254)));
        write_reg(CFG_UNMAPPED, 8'($urandom));
        send_idle_pct = 14;
        stall_pct = 14;
        run_traffic(100);
        drain_block();

        // Back pressure: the result side holds off for a long stretch while
        // the driver keeps offering bytes, so the receiver fills and stalls.
        write_reg(CFG_HEADER, HEADER_RESET);
        write_reg(CFG_ESCAPE, ESCAPE_RESET);
        write_reg(CFG_LIMIT, LIMIT_RESET);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        run_traffic(80);
        drain_block();

        if (rx_results_q.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived", rx_results_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- escaped_frame_receiver.f -----
+incdir+hdl
hdl/efr_pkg.sv
hdl/efr_deframer.sv
hdl/efr_out_reg.sv
hdl/escaped_frame_receiver.sv
bench/escaped_frame_receiver_tb.sv
